// File: hdl/lph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear probe hash map package
// Table size, hash constant, operation and status codes, and the word types
// shared by the map's modules.
// ----------------------------------------------------------------------------
package lph_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  // Multiplicative hash constant.
  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Request word.
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
    logic [63:0] value_in;
  } req_word_t;

  // Response word.
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value_out;
  } rsp_word_t;

  // One slot of the table as held in memory.
  typedef struct packed {
    logic        used;
    logic [31:0] key;
    logic [63:0] value;
  } slot_word_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE
  } state_t;

endpackage : lph_pkg
`default_nettype wire

// File: hdl/lph_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : lph_ram
`default_nettype wire

// File: hdl/lph_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hash unit
// Multiplies the key by the hash constant modulo 2^32, registers the product
// and reduces it to the home slot index.
// ----------------------------------------------------------------------------
module lph_hash (
  input  wire logic                    clk,
  input  wire logic                    load,
  input  wire logic [31:0]             key,
  output logic      [lph_pkg::IDX_W-1:0] home
);
  import lph_pkg::*;

  logic [31:0] hash;

  // Low half of the product, registered before any further use.
  always_ff @(posedge clk) begin
    if (load) begin
      hash <= 32'(key * HASH_MULT);
    end
  end

  // The table size is a power of two, so the reduction is a mask.
  assign home = IDX_W'(hash % TABLE_ENTRIES);

endmodule : lph_hash
`default_nettype wire

// File: hdl/linear_probe_hash_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear probe hash map
// Open-addressed map from 32-bit keys to 64-bit values with insert, lookup
// and remove, probing one slot per cycle with wrap-around.
// ----------------------------------------------------------------------------
// Flow: an accepted word passes through the hash state, then one probe step per
// slot probed (1 to TABLE_ENTRIES slots), and is then loaded into the output
// register; a stalled output register holds the sequencer on the last slot until it frees.
// A new word is accepted only in the idle state, after the last has finished; the
// single slot memory read port returns one slot per cycle.
// Reset: a clearing pass over all TABLE_ENTRIES slots zeroes every slot; req_stall
// stays high until it completes.
module linear_probe_hash_map (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire lph_pkg::req_word_t req,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output lph_pkg::rsp_word_t      rsp
);
  import lph_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] slot, slot_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] home;
  req_word_t        item;
  rsp_word_t        rsp_next;
  slot_word_t       rd_word, wr_word;
  logic             ram_we;
  logic             req_take;
  logic             rsp_load;
  logic             probe_done;
  logic             hit;
  logic             out_free;

  // Hash unit, loaded with the key of an accepted word.
  lph_hash u_hash (
    .clk  (clk),
    .load (req_take),
    .key  (req.key),
    .home (home)
  );

  // Slot memory: used mark, key and value in one word.
  lph_ram #(
    .WIDTH ($bits(slot_word_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (wr_word),
    .raddr (slot_next),
    .rdata (rd_word)
  );

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign hit       = rd_word.used && (rd_word.key == item.key);

  // State register and probe position.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      slot  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
      cnt   <= cnt_next;
    end
  end

  // The accepted word is held for the whole probe.
  always_ff @(posedge clk) begin
    if (req_take) begin
      item <= req;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // Sequencer: clearing pass, hashing, then one slot per cycle, holding on the last slot while the output is stalled.
  always_comb begin
    state_next = state;
    slot_next  = slot;
    cnt_next   = cnt;
    ram_we     = 1'b0;
    wr_word    = '0;
    rsp_load   = 1'b0;
    rsp_next   = '{status: ST_MISSING, value_out: 64'd0};
    probe_done = 1'b0;

    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (slot == LAST_IDX) begin
          slot_next  = '0;
          state_next = S_IDLE;
        end else begin
          slot_next = slot + 1'b1;
        end
      end

      S_IDLE: begin
        if (req_take) begin
          state_next = S_HASH;
        end
      end

      S_HASH: begin
        slot_next  = home;
        cnt_next   = '0;
        state_next = S_PROBE;
      end

      S_PROBE: begin
        // Decide on the slot whose word has just been read.
        case (item.operation)
          OP_INSERT: begin
            if (!rd_word.used || hit) begin
              probe_done       = 1'b1;
              rsp_next.status  = ST_OK;
              ram_we           = 1'b1;
              wr_word          = '{used: 1'b1, key: item.key, value: item.value_in};
            end else if (cnt == LAST_IDX) begin
              probe_done      = 1'b1;
              rsp_next.status = ST_FULL;
            end
          end
          OP_LOOKUP, OP_REMOVE: begin
            if (!rd_word.used) begin
              probe_done = 1'b1;
            end else if (hit) begin
              probe_done      = 1'b1;
              rsp_next.status = ST_OK;
              if (item.operation == OP_LOOKUP) begin
                rsp_next.value_out = rd_word.value;
              end else begin
                ram_we = 1'b1;
              end
            end else if (cnt == LAST_IDX) begin
              probe_done = 1'b1;
            end
          end
          default: begin
            probe_done = 1'b1;
          end
        endcase

        if (probe_done) begin
          // Finish only once the output register can take the word.
          if (out_free) begin
            rsp_load   = 1'b1;
            state_next = S_IDLE;
          end else begin
            ram_we = 1'b0;
          end
        end else begin
          slot_next = (slot == LAST_IDX) ? '0 : slot + 1'b1;
          cnt_next  = cnt + 1'b1;
        end
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // A reset always leaves the request side stalled for the clearing pass.
  a_reset_stalls : assert property (@(posedge clk) rst |=> req_stall)
    else $error("request side not stalled after reset");

  // A response is only loaded when the output register is free.
  a_rsp_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> (!rsp_valid || !rsp_stall))
    else $error("response overwritten while held");

  // During a probe the table is written only by the step that finishes it.
  a_write_on_finish : assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == S_PROBE) |-> rsp_load)
    else $error("slot written without finishing the request");

  // An accepted word is always hashed in the following cycle.
  a_take_then_hash : assert property (@(posedge clk) disable iff (rst)
    req_take |=> (state == S_HASH))
    else $error("accepted word not hashed");

endmodule : linear_probe_hash_map
`default_nettype wire
